/* design/dne_pkg.sv */
package dne_pkg;

    localparam int DW = 16;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;
    localparam logic [14:0] ONE_Q15 = 15'd32767;

    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIFF_THRESHOLD = 2'd2;

    // One classified pixel handed from the front end to the normal unit.
    typedef struct packed {
        logic               int_pix;
        logic               border;
        logic [11:0]        row;
        logic [9:0]         col;
        logic signed [16:0] diff_a;
        logic signed [16:0] diff_b;
    } t_item;

    // A neighbor that strays too far from the center counts as zero.
    function automatic logic [DW-1:0] keep_nb(input logic [DW-1:0] ctr,
                                              input logic [DW-1:0] nb,
                                              input logic [DW-1:0] thr);
        logic [DW-1:0] diff_mag;
        diff_mag = (ctr > nb) ? ctr - nb : nb - ctr;
        return (diff_mag > thr) ? '0 : nb;
    endfunction

endpackage

/* design/depth_normal_estimator.sv */
// Front end, per pixel: accept, three reads of the line memory, then write-back,
// which waits while a queued pixel finds the queue full. Border-only pixels go
// from B_IDLE straight to B_SEND in the normal unit. Interior pixels take two
// squarings, then per component 32 division steps and 16 square-root steps, one per cycle.
// A 4-entry queue between the two parts lets the front run ahead.
// Synchronous active-low reset clears control state and loads default registers.
module depth_normal_estimator
    import dne_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int DEPTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_depth,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [11:0]        o_row,
    output logic [9:0]         o_col,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic [14:0]        o_normal_z,
    output logic               o_last
);

    logic [10:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic [15:0] r_diff_threshold;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item item;
    t_item head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= 11'd640;
            r_frame_height   <= 12'd480;
            r_diff_threshold <= 16'd20;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[11:0];
                CFG_DIFF_THRESHOLD: r_diff_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dne_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_depth         (i_depth),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .i_diff_threshold(r_diff_threshold),
        .i_fifo_full     (full),
        .o_push          (push),
        .o_item          (item)
    );

    dne_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (item),
        .i_pop  (pop),
        .o_head (head),
        .o_full (full),
        .o_empty(empty)
    );

    dne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_empty(empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z),
        .o_last      (o_last)
    );

endmodule

/* design/dne_fifo.sv */
module dne_fifo
    import dne_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* design/dne_front.sv */
module dne_front
    import dne_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int DEPTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_depth,
    input  logic [10:0] i_frame_width,
    input  logic [11:0] i_frame_height,
    input  logic [15:0] i_diff_threshold,
    input  logic        i_fifo_full,
    output logic        o_push,
    output t_item       o_item
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

    typedef enum logic [2:0] {S_IDLE, S_RL, S_RC, S_RR, S_WR} t_state;

    t_state r_state;
    logic [2*DEPTH_BITS-1:0] r_mem [MAX_WIDTH];
    logic [2*DEPTH_BITS-1:0] r_rdata;
    logic [11:0]             r_row;
    logic [AW-1:0]           r_col;
    logic [11:0]             r_rr;
    logic [AW-1:0]           r_cc;
    logic [DEPTH_BITS-1:0]   r_d;
    logic [DEPTH_BITS-1:0]   r_lf;
    logic [DEPTH_BITS-1:0]   r_up;
    logic [DEPTH_BITS-1:0]   r_ctr;
    logic                    r_int;
    logic                    r_bdr;

    logic [12:0]   fw;
    logic [12:0]   w_eff;
    logic [11:0]   h_eff;
    logic          wrap;
    logic [11:0]   rr;
    logic [AW-1:0] cc;
    logic [12:0]   cc1;
    logic [12:0]   rr1;
    logic          interior;
    logic          border;
    logic [AW-1:0] rd_addr;
    logic          need_push;
    logic          go;
    logic [DW-1:0] ctr_k;
    logic [DW-1:0] lf_k;
    logic [DW-1:0] up_k;
    logic [DW-1:0] rt_k;
    logic [DW-1:0] dn_k;

    always_comb begin
        fw    = {2'b00, i_frame_width};
        w_eff = (fw > MAXW) ? MAXW : ((fw < 13'd3) ? 13'd3 : fw);
        h_eff = (i_frame_height < 12'd3) ? 12'd3 : i_frame_height;
        // A size change can leave the position outside the frame.
        wrap  = (13'(r_col) >= w_eff) || (r_row >= h_eff);
        rr    = wrap ? '0 : r_row;
        cc    = wrap ? '0 : r_col;
        cc1   = 13'(cc) + 13'd1;
        rr1   = 13'(rr) + 13'd1;
        interior = (rr >= 12'd2) && (cc != '0) && ((13'(cc) + 13'd2) <= w_eff);
        border   = (rr == '0) || (rr == h_eff - 12'd1) || (cc == '0) || (cc1 == w_eff);
    end

    always_comb begin
        case (r_state)
            S_RL:    rd_addr = r_cc - 1'b1;
            S_RC:    rd_addr = r_cc;
            default: rd_addr = r_cc + 1'b1;
        endcase
    end

    always_comb begin
        ctr_k = DW'(r_ctr);
        lf_k  = keep_nb(ctr_k, DW'(r_lf), i_diff_threshold);
        up_k  = keep_nb(ctr_k, DW'(r_up), i_diff_threshold);
        rt_k  = keep_nb(ctr_k, DW'(r_rdata[DEPTH_BITS-1:0]), i_diff_threshold);
        dn_k  = keep_nb(ctr_k, DW'(r_d), i_diff_threshold);
        o_item.int_pix = r_int;
        o_item.border  = r_bdr;
        o_item.row     = r_rr;
        o_item.col     = 10'(r_cc);
        o_item.diff_a  = $signed({1'b0, rt_k}) - $signed({1'b0, lf_k});
        o_item.diff_b  = $signed({1'b0, dn_k}) - $signed({1'b0, up_k});
    end

    assign need_push  = r_int || r_bdr;
    assign go         = !need_push || !i_fifo_full;
    assign o_push     = (r_state == S_WR) && need_push && !i_fifo_full;
    assign o_in_ready = (r_state == S_IDLE);

    // Each entry holds the sample two rows up above the one a row up.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (r_state == S_WR && go) begin
            r_mem[r_cc] <= {r_ctr, r_d};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rr  <= rr;
                        r_cc  <= cc;
                        r_d   <= i_depth[DEPTH_BITS-1:0];
                        r_int <= interior;
                        r_bdr <= border;
                        if (cc1 >= w_eff) begin
                            r_col <= '0;
                            r_row <= (rr1 >= 13'(h_eff)) ? '0 : rr1[11:0];
                        end else begin
                            r_col <= cc1[AW-1:0];
                            r_row <= rr;
                        end
                        r_state <= S_RL;
                    end
                end
                S_RL: begin
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_lf    <= r_rdata[2*DEPTH_BITS-1:DEPTH_BITS];
                    r_state <= S_RR;
                end
                S_RR: begin
                    r_up    <= r_rdata[2*DEPTH_BITS-1:DEPTH_BITS];
                    r_ctr   <= r_rdata[DEPTH_BITS-1:0];
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/dne_back.sv */
module dne_back
    import dne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fifo_empty,
    input  t_item              i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [11:0]        o_row,
    output logic [9:0]         o_col,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic [14:0]        o_normal_z,
    output logic               o_last
);

    typedef enum logic [3:0] {
        B_IDLE, B_SQA, B_SQB, B_SUM, B_LOAD, B_DIV, B_SQRT, B_FIN, B_SEND
    } t_state;

    t_state      r_state;
    t_item       r_item;
    logic [31:0] r_a2;
    logic [31:0] r_b2;
    logic [33:0] r_s;
    logic [33:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_v;
    logic [31:0] r_res;
    logic [31:0] r_bit;
    logic [4:0]  r_cnt;
    logic [1:0]  r_comp;
    logic [15:0] r_nx;
    logic [15:0] r_ny;
    logic        r_pend;

    logic [16:0] abs_a;
    logic [16:0] abs_b;
    logic [15:0] mul_in;
    logic [31:0] prod;
    logic [31:0] ksq;
    logic [34:0] rem2;
    logic        dge;
    logic [32:0] trial;
    logic        sge;
    logic [16:0] rnd;
    logic [16:0] qs;
    logic        k_pos;
    logic [15:0] comp_val;

    always_comb begin
        abs_a  = r_item.diff_a[16] ? 17'(-r_item.diff_a) : 17'(r_item.diff_a);
        abs_b  = r_item.diff_b[16] ? 17'(-r_item.diff_b) : 17'(r_item.diff_b);
        mul_in = (r_state == B_SQA) ? abs_a[15:0] : abs_b[15:0];
        prod   = mul_in * mul_in;
        case (r_comp)
            2'd0:    ksq = r_a2;
            2'd1:    ksq = r_b2;
            default: ksq = 32'd4;
        endcase
        // Restoring division step; the quotient of k*k*2^32 / s fits 32 bits.
        rem2  = {r_rem, 1'b0};
        dge   = rem2 >= {1'b0, r_s};
        // Integer square root step, two bits of the radicand at a time.
        trial = {1'b0, r_res} + {1'b0, r_bit};
        sge   = {1'b0, r_v} >= trial;
        rnd   = 17'((33'(r_res) + 33'd1) >> 1);
        case (r_comp)
            2'd0:    k_pos = !r_item.diff_a[16] && (r_item.diff_a != '0);
            2'd1:    k_pos = !r_item.diff_b[16] && (r_item.diff_b != '0);
            default: k_pos = 1'b0;
        endcase
        if (k_pos) begin
            qs       = (rnd > 17'd32768) ? 17'd32768 : rnd;
            comp_val = 16'(17'h10000 - qs);
        end else begin
            qs       = (rnd > 17'd32767) ? 17'd32767 : rnd;
            comp_val = qs[15:0];
        end
    end

    assign o_pop = (r_state == B_IDLE) && !i_fifo_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            o_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_fifo_empty) begin
                        r_item <= i_head;
                        if (i_head.int_pix) begin
                            r_state <= B_SQA;
                        end else begin
                            o_row       <= i_head.row;
                            o_col       <= i_head.col;
                            o_normal_x  <= '0;
                            o_normal_y  <= '0;
                            o_normal_z  <= ONE_Q15;
                            o_last      <= 1'b1;
                            o_out_valid <= 1'b1;
                            r_pend      <= 1'b0;
                            r_state     <= B_SEND;
                        end
                    end
                end
                B_SQA: begin
                    r_a2    <= prod;
                    r_state <= B_SQB;
                end
                B_SQB: begin
                    r_b2    <= prod;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_s     <= 34'(r_a2) + 34'(r_b2) + 34'd4;
                    r_comp  <= 2'd0;
                    r_state <= B_LOAD;
                end
                B_LOAD: begin
                    r_rem   <= 34'(ksq);
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem <= dge ? 34'(rem2 - {1'b0, r_s}) : rem2[33:0];
                    r_q   <= {r_q[30:0], dge};
                    // The step count wraps to zero after the last step.
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_v     <= {r_q[30:0], dge};
                        r_res   <= '0;
                        r_bit   <= 32'h4000_0000;
                        r_state <= B_SQRT;
                    end
                end
                B_SQRT: begin
                    if (sge) begin
                        r_v   <= r_v - trial[31:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd15) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    case (r_comp)
                        2'd0: begin
                            r_nx    <= comp_val;
                            r_comp  <= 2'd1;
                            r_state <= B_LOAD;
                        end
                        2'd1: begin
                            r_ny    <= comp_val;
                            r_comp  <= 2'd2;
                            r_state <= B_LOAD;
                        end
                        default: begin
                            o_row       <= r_item.row - 12'd1;
                            o_col       <= r_item.col;
                            o_normal_x  <= r_nx;
                            o_normal_y  <= r_ny;
                            o_normal_z  <= comp_val[14:0];
                            o_last      <= !r_item.border;
                            o_out_valid <= 1'b1;
                            r_pend      <= r_item.border;
                            r_state     <= B_SEND;
                        end
                    endcase
                end
                B_SEND: begin
                    if (i_out_ready) begin
                        // A bottom-row pixel still owes its own border item.
                        if (r_pend) begin
                            o_row      <= r_item.row;
                            o_col      <= r_item.col;
                            o_normal_x <= '0;
                            o_normal_y <= '0;
                            o_normal_z <= ONE_Q15;
                            o_last     <= 1'b1;
                            r_pend     <= 1'b0;
                        end else begin
                            o_out_valid <= 1'b0;
                            r_state     <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

/* design/dne_checker.sv */
module dne_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [11:0]        o_row,
    input logic [9:0]         o_col,
    input logic signed [15:0] o_normal_x,
    input logic               o_last
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before the item was taken");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_row) && $stable(o_col)
            && $stable(o_normal_x) && $stable(o_last))
        else $error("output payload changed while stalled");

    // A result that is not last belongs to an interior pixel.
    a_inner_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_col != 10'd0)
        else $error("non-final result on column zero");

    // The border result of a bottom-row pixel follows at once.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_last)
        else $error("second result of a pixel did not follow");

endmodule

bind depth_normal_estimator dne_checker u_dne_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_row      (o_row),
    .o_col      (o_col),
    .o_normal_x (o_normal_x),
    .o_last     (o_last)
);
